// ----- rtl/core/pba_pkg.sv -----
`timescale 1ns / 1ps

package pba_pkg;

   // Field widths of the request, response and page count register
   localparam int OP_W     = 3;
   localparam int START_W  = 10;
   localparam int PAGE_W   = 11;
   localparam int STATUS_W = 2;

   // Pages are numbered below this span
   localparam int PAGE_SPAN = 2048;

   localparam logic [PAGE_W-1:0] PAGE_COUNT_RESET = 11'd1024;

   localparam logic [OP_W-1:0] OP_SET   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
   localparam logic [OP_W-1:0] OP_TEST  = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
   localparam logic [OP_W-1:0] OP_COUNT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic load;    // latch request, rewind the walk
      logic issue;   // read the next bitmap word
      logic sweep;   // zero the word at the sweep address
      logic finish;  // load the response register
   } ctl_cmd_type;

   typedef struct packed {
      logic more;        // words remain below the walk limit
      logic found;       // free run located
      logic inflight;    // a word read is being processed
      logic sweep_last;  // sweep is at the last word
   } dp_sts_type;

endpackage

// ----- rtl/core/pba_req_if.sv -----
`timescale 1ns / 1ps

interface pba_req_if;
   logic                         valid;
   logic                         ready;
   logic [pba_pkg::OP_W-1:0]     operation;
   logic [pba_pkg::START_W-1:0]  start_page;
   logic [pba_pkg::PAGE_W-1:0]   length;

   modport source (output valid, output operation, output start_page, output length,
                   input ready);
   modport sink   (input valid, input operation, input start_page, input length,
                   output ready);
endinterface

// ----- rtl/core/pba_rsp_if.sv -----
`timescale 1ns / 1ps

interface pba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pba_pkg::STATUS_W-1:0]  status;
   logic [pba_pkg::START_W-1:0]   page_index;
   logic                          bit_value;
   logic [pba_pkg::PAGE_W-1:0]    used_count;
   logic [pba_pkg::PAGE_W-1:0]    free_count;

   modport source (output valid, output status, output page_index, output bit_value,
                   output used_count, output free_count, input ready);
   modport sink   (input valid, input status, input page_index, input bit_value,
                   input used_count, input free_count, output ready);
endinterface

// ----- rtl/core/pba_ram.sv -----
`timescale 1ns / 1ps

module pba_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/core/pba_ctrl.sv -----
`timescale 1ns / 1ps

module pba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pba_pkg::dp_sts_type  sts,
   output pba_pkg::ctl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_WALK  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.more && !sts.found) begin
               cmd.issue = 1'b1;
            end else if (!sts.inflight) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold the result until the output slot frees up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_inflight_walk: assert property (@(posedge clock) disable iff (reset)
      sts.inflight |-> (state_ff == S_WALK))
      else $error("word in flight outside the walk");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised without a finished walk");

endmodule

// ----- rtl/core/pba_dpath.sv -----
`timescale 1ns / 1ps

module pba_dpath #(
   parameter int MAX_PAGES = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [pba_pkg::PAGE_W-1:0]     csr_wr_data,
   input  logic [pba_pkg::OP_W-1:0]       req_operation,
   input  logic [pba_pkg::START_W-1:0]    req_start_page,
   input  logic [pba_pkg::PAGE_W-1:0]     req_length,
   input  pba_pkg::ctl_cmd_type           cmd,
   output pba_pkg::dp_sts_type            sts,
   output logic [pba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pba_pkg::START_W-1:0]    rsp_page_index,
   output logic                           rsp_bit_value,
   output logic [pba_pkg::PAGE_W-1:0]     rsp_used_count,
   output logic [pba_pkg::PAGE_W-1:0]     rsp_free_count
);

   localparam int PW        = pba_pkg::PAGE_W;
   localparam int EW        = pba_pkg::PAGE_W + 1;
   localparam int SW        = pba_pkg::START_W;
   localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BASE_W    = $clog2(pba_pkg::PAGE_SPAN + WORD_BITS);
   localparam int IDX_W     = $clog2(WORD_BITS);
   localparam int POP_W     = $clog2(WORD_BITS + 1);
   localparam int LEVELS    = $clog2(WORD_BITS);

   // configuration and latched request
   logic [PW-1:0]                  page_count_ff, page_count_in;
   logic [PW-1:0]                  pc_eff;
   logic [pba_pkg::OP_W-1:0]       op_ff, op_in;
   logic [PW-1:0]                  start_ff, start_in;
   logic [PW-1:0]                  len_ff, len_in;
   logic [PW-1:0]                  limit_ff, limit_in;
   logic [pba_pkg::STATUS_W-1:0]   pre_status_ff, pre_status_in;

   // walk pointers and the word being processed
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic               proc_vld_ff, proc_vld_in;
   logic [ADDR_W-1:0]  proc_addr_ff, proc_addr_in;
   logic [BASE_W-1:0]  proc_base_ff, proc_base_in;

   // accumulators
   logic [BASE_W-1:0]  carry_ff, carry_in;
   logic [PW-1:0]      used_ff, used_in;
   logic               found_ff, found_in;
   logic [SW-1:0]      hit_ff, hit_in;
   logic               bit_ff, bit_in;

   // response register
   logic [pba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SW-1:0]                rsp_index_ff, rsp_index_in;
   logic                         rsp_bit_ff, rsp_bit_in;
   logic [PW-1:0]                rsp_used_ff, rsp_used_in;
   logic [PW-1:0]                rsp_free_ff, rsp_free_in;

   // bitmap memory
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic [WORD_BITS-1:0]  rd_data;

   // per-word logic
   logic [BASE_W-1:0]     page_of [WORD_BITS];
   logic [WORD_BITS-1:0]  in_pc, in_rng, at_start, used_m;
   logic                  has_p [LEVELS+1][WORD_BITS];
   logic [IDX_W-1:0]      pos_p [LEVELS+1][WORD_BITS];
   logic [BASE_W-1:0]     run_len [WORD_BITS];
   logic                  hit_any;
   logic [IDX_W-1:0]      hit_idx;
   logic [BASE_W-1:0]     hit_page;
   logic [POP_W-1:0]      pop;
   logic                  bit_hit;
   logic [WORD_BITS-1:0]  new_word;
   logic [PW-1:0]         req_start_ext;
   logic [EW-1:0]         req_end;

   assign pc_eff = (32'(page_count_ff) < MAX_PAGES) ? page_count_ff : PW'(MAX_PAGES);

   pba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // page number and per-bit masks for the word in process
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         page_of[i]  = proc_base_ff + BASE_W'(i);
         in_pc[i]    = page_of[i] < BASE_W'(pc_eff);
         in_rng[i]   = (page_of[i] >= BASE_W'(start_ff)) && (page_of[i] < BASE_W'(limit_ff));
         at_start[i] = page_of[i] == BASE_W'(start_ff);
         // pages past the count act as used, so no run crosses them
         used_m[i]   = rd_data[i] || !in_pc[i];
      end
   end

   // latest used bit at or below each position, log-depth prefix
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         has_p[0][i] = used_m[i];
         pos_p[0][i] = IDX_W'(i);
      end
      for (int lv = 0; lv < LEVELS; lv++) begin
         for (int i = 0; i < WORD_BITS; i++) begin
            has_p[lv+1][i] = has_p[lv][i];
            pos_p[lv+1][i] = pos_p[lv][i];
            if (!has_p[lv][i] && (i >= (1 << lv))) begin
               if (has_p[lv][i - (1 << lv)]) begin
                  has_p[lv+1][i] = 1'b1;
                  pos_p[lv+1][i] = pos_p[lv][i - (1 << lv)];
               end
            end
         end
      end
   end

   // free run ending at each bit, lowest bit that completes the run
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (has_p[LEVELS][i]) begin
            run_len[i] = BASE_W'(i) - BASE_W'(pos_p[LEVELS][i]);
         end else begin
            run_len[i] = BASE_W'(i + 1) + carry_ff;
         end
      end
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (run_len[i] >= BASE_W'(len_ff)) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
      hit_page = proc_base_ff + BASE_W'(hit_idx) + BASE_W'(1) - BASE_W'(len_ff);
   end

   always_comb begin
      pop = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         pop = pop + POP_W'(rd_data[i] && in_pc[i]);
      end
      bit_hit  = |(rd_data & at_start);
      new_word = (op_ff == pba_pkg::OP_SET) ? (rd_data | in_rng) : (rd_data & ~in_rng);
   end

   // write port: clearing sweep or read-modify-write of a range
   always_comb begin
      wr_en   = cmd.sweep ||
                (proc_vld_ff && ((op_ff == pba_pkg::OP_SET) || (op_ff == pba_pkg::OP_CLEAR)));
      wr_addr = cmd.sweep ? addr_ff : proc_addr_ff;
      wr_data = cmd.sweep ? '0 : new_word;
   end

   assign req_start_ext = PW'(req_start_page);
   // one bit wider, so start_page + length never wraps
   assign req_end       = EW'(req_start_page) + EW'(req_length);

   always_comb begin
      page_count_in = csr_wr_en ? csr_wr_data : page_count_ff;
      op_in         = op_ff;
      start_in      = start_ff;
      len_in        = len_ff;
      limit_in      = limit_ff;
      pre_status_in = pre_status_ff;
      addr_in       = addr_ff;
      base_in       = base_ff;
      proc_vld_in   = cmd.issue;
      proc_addr_in  = addr_ff;
      proc_base_in  = base_ff;
      carry_in      = carry_ff;
      used_in       = used_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      bit_in        = bit_ff;

      if (cmd.load) begin
         op_in         = req_operation;
         start_in      = req_start_ext;
         len_in        = req_length;
         addr_in       = '0;
         base_in       = '0;
         carry_in      = '0;
         used_in       = '0;
         found_in      = 1'b0;
         hit_in        = '0;
         bit_in        = 1'b0;
         pre_status_in = pba_pkg::ST_OK;
         limit_in      = '0;
         // a rejected request walks no words
         case (req_operation)
            pba_pkg::OP_SET, pba_pkg::OP_CLEAR: begin
               if (req_end > EW'(pc_eff)) begin
                  pre_status_in = pba_pkg::ST_RANGE;
               end else begin
                  limit_in = req_end[PW-1:0];
               end
            end
            pba_pkg::OP_TEST: begin
               if (req_start_ext >= pc_eff) begin
                  pre_status_in = pba_pkg::ST_RANGE;
               end else begin
                  limit_in = req_start_ext + PW'(1);
               end
            end
            pba_pkg::OP_FIND: begin
               if ((req_length == '0) || (req_length > pc_eff)) begin
                  pre_status_in = pba_pkg::ST_NOTFOUND;
               end else begin
                  limit_in = pc_eff;
               end
            end
            pba_pkg::OP_COUNT: begin
               limit_in = pc_eff;
            end
            default: begin
               pre_status_in = pba_pkg::ST_RANGE;
            end
         endcase
      end

      if (cmd.issue) begin
         addr_in = addr_ff + ADDR_W'(1);
         base_in = base_ff + BASE_W'(WORD_BITS);
      end
      if (cmd.sweep) begin
         addr_in = addr_ff + ADDR_W'(1);
      end

      // drop words read after the run was found
      if (proc_vld_ff && !found_ff) begin
         case (op_ff)
            pba_pkg::OP_FIND: begin
               carry_in = run_len[WORD_BITS-1];
               if (hit_any) begin
                  found_in = 1'b1;
                  hit_in   = hit_page[SW-1:0];
               end
            end
            pba_pkg::OP_COUNT: begin
               used_in = used_ff + PW'(pop);
            end
            pba_pkg::OP_TEST: begin
               bit_in = bit_ff || bit_hit;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;
      if (cmd.finish) begin
         if (op_ff == pba_pkg::OP_FIND) begin
            rsp_status_in = found_ff ? pba_pkg::ST_OK : pba_pkg::ST_NOTFOUND;
         end else begin
            rsp_status_in = pre_status_ff;
         end
         rsp_index_in = found_ff ? hit_ff : '0;
         rsp_bit_in   = bit_ff;
         rsp_used_in  = (op_ff == pba_pkg::OP_COUNT) ? used_ff : '0;
         rsp_free_in  = (op_ff == pba_pkg::OP_COUNT) ? (pc_eff - used_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= pba_pkg::PAGE_COUNT_RESET;
         addr_ff       <= '0;
         proc_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         limit_ff      <= '0;
         base_ff       <= '0;
      end else begin
         page_count_ff <= page_count_in;
         addr_ff       <= addr_in;
         proc_vld_ff   <= proc_vld_in;
         found_ff      <= found_in;
         limit_ff      <= limit_in;
         base_ff       <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      pre_status_ff <= pre_status_in;
      proc_addr_ff  <= proc_addr_in;
      proc_base_ff  <= proc_base_in;
      carry_ff      <= carry_in;
      used_ff       <= used_in;
      hit_ff        <= hit_in;
      bit_ff        <= bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign sts.more       = base_ff < BASE_W'(limit_ff);
   assign sts.found      = found_ff;
   assign sts.inflight   = proc_vld_ff;
   assign sts.sweep_last = (addr_ff == ADDR_W'(NUM_WORDS - 1));

   assign rsp_status     = rsp_status_ff;
   assign rsp_page_index = rsp_index_ff;
   assign rsp_bit_value  = rsp_bit_ff;
   assign rsp_used_count = rsp_used_ff;
   assign rsp_free_count = rsp_free_ff;

   a_word_below_limit: assert property (@(posedge clock) disable iff (reset)
      proc_vld_ff |-> (proc_base_ff < BASE_W'(limit_ff)))
      else $error("processed word lies past the walk limit");

   a_found_only_search: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (op_ff == pba_pkg::OP_FIND))
      else $error("run found flag set outside a search");

endmodule

// ----- rtl/core/page_bitmap_allocator_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Payload
// req_bus   in         valid/ready      operation, start_page, length
// rsp_bus   out        valid/ready      status, page_index, bit_value, used_count, free_count
// csr       in         csr_wr_en        csr_wr_data (page_count)
//
// A request reads ceil(limit / WORD_BITS) bitmap words from word 0, one per cycle;
// limit is start_page + length (set, clear), start_page + 1 (test), page count (search, count).
// A search stops one word after the word that completes the run; a rejected request reads none.
// The response is loaded in S_DONE once the output slot is free, then S_IDLE takes the next
// request. After reset a sweep zeroes every bitmap word with ready low; a waiting response
// stalls the next one.

module page_bitmap_allocator_unit #(
   parameter int MAX_PAGES = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   pba_req_if.sink                    req_bus,
   pba_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [pba_pkg::PAGE_W-1:0] csr_wr_data
);

   pba_pkg::ctl_cmd_type cmd;
   pba_pkg::dp_sts_type  sts;

   pba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pba_dpath #(
      .MAX_PAGES (MAX_PAGES),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_operation  (req_bus.operation),
      .req_start_page (req_bus.start_page),
      .req_length     (req_bus.length),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_status     (rsp_bus.status),
      .rsp_page_index (rsp_bus.page_index),
      .rsp_bit_value  (rsp_bus.bit_value),
      .rsp_used_count (rsp_bus.used_count),
      .rsp_free_count (rsp_bus.free_count)
   );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int OP_W     = pba_pkg::OP_W;
   localparam int START_W  = pba_pkg::START_W;
   localparam int PAGE_W   = pba_pkg::PAGE_W;
   localparam int STATUS_W = pba_pkg::STATUS_W;

   localparam int ZONE_MAX_PAGES = 1024;
   localparam int ZONE_WORD_BITS = 32;
   localparam int ZONE_WORDS     = ZONE_MAX_PAGES / ZONE_WORD_BITS;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;

   // operation codes with no defined meaning
   localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd5;
   localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_C = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  page_index;
      logic                bit_value;
      logic [PAGE_W-1:0]   used_count;
      logic [PAGE_W-1:0]   free_count;
   } alloc_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [PAGE_W-1:0] csr_wr_data;

   pba_req_if req_bus ();
   pba_rsp_if rsp_bus ();

   page_bitmap_allocator_unit #(
      .MAX_PAGES (ZONE_MAX_PAGES),
      .WORD_BITS (ZONE_WORD_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the allocator state
   logic [ZONE_WORD_BITS-1:0] shadow_words [ZONE_WORDS];
   logic [PAGE_W-1:0]         zone_pages;

   alloc_result_type pending_results [$];
   alloc_result_type observed_result;
   alloc_result_type oldest_result;

   int mismatch_count;
   int cycle_count;
   int send_idle_pct;
   int rsp_stall_pct;
   int hold_cycles;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int effective_pages();
      return (zone_pages > ZONE_MAX_PAGES) ? ZONE_MAX_PAGES : int'(zone_pages);
   endfunction

   function automatic bit page_is_used(input int page);
      return shadow_words[page / ZONE_WORD_BITS][page % ZONE_WORD_BITS];
   endfunction

   // Apply one request to the shadow bitmap and return the response it must produce
   function automatic alloc_result_type compute_alloc_result(input logic [OP_W-1:0] op,
                                                             input logic [START_W-1:0] first,
                                                             input logic [PAGE_W-1:0] len);
      alloc_result_type res;
      int pc;
      int i;
      int run_first;
      int run_len;
      int used;
      bit found;
      res = '0;
      pc = effective_pages();
      run_first = 0;
      run_len = 0;
      used = 0;
      found = 1'b0;
      case (op)
         pba_pkg::OP_SET, pba_pkg::OP_CLEAR: begin
            if (int'(first) + int'(len) > pc) begin
               res.status = pba_pkg::ST_RANGE;
            end else begin
               for (i = int'(first); i < int'(first) + int'(len); i++)
                  shadow_words[i / ZONE_WORD_BITS][i % ZONE_WORD_BITS] = (op == pba_pkg::OP_SET);
               res.status = pba_pkg::ST_OK;
            end
         end
         pba_pkg::OP_TEST: begin
            if (int'(first) >= pc) res.status = pba_pkg::ST_RANGE;
            else res.bit_value = page_is_used(int'(first));
         end
         pba_pkg::OP_FIND: begin
            if (len != 0 && int'(len) <= pc) begin
               for (i = 0; i < pc && !found; i++) begin
                  if (!page_is_used(i)) begin
                     if (run_len == 0) run_first = i;
                     run_len++;
                     if (run_len >= int'(len)) found = 1'b1;
                  end else begin
                     run_len = 0;
                  end
               end
            end
            if (found) res.page_index = START_W'(run_first);
            else res.status = pba_pkg::ST_NOTFOUND;
         end
         pba_pkg::OP_COUNT: begin
            for (i = 0; i < pc; i++)
               if (page_is_used(i)) used++;
            res.used_count = PAGE_W'(used);
            res.free_count = PAGE_W'(pc - used);
         end
         default: res.status = pba_pkg::ST_RANGE;
      endcase
      return res;
   endfunction

   // Offer one request, hold it until it is accepted, then predict its response
   task automatic issue_request(input logic [OP_W-1:0] op, input logic [START_W-1:0] first,
                                input logic [PAGE_W-1:0] len);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.start_page <= first;
      req_bus.length     <= len;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(compute_alloc_result(op, first, len));
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_page_count(input logic [PAGE_W-1:0] value);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      zone_pages = value;
      @(negedge clock);
   endtask

   // Mostly well-formed requests sized to the current zone, some raw noise
   task automatic issue_random_item();
      int pc;
      int pick;
      int len;
      int first;
      logic [OP_W-1:0] op;
      pc = effective_pages();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         issue_request(OP_W'($urandom_range(0, 7)), START_W'($urandom_range(0, 1023)),
                       PAGE_W'($urandom_range(0, 2047)));
      end else begin
         if (pick < 36) op = pba_pkg::OP_SET;
         else if (pick < 62) op = pba_pkg::OP_CLEAR;
         else if (pick < 74) op = pba_pkg::OP_TEST;
         else if (pick < 91) op = pba_pkg::OP_FIND;
         else op = pba_pkg::OP_COUNT;
         case (op)
            pba_pkg::OP_SET, pba_pkg::OP_CLEAR: begin
               if ($urandom_range(0, 9) == 0) len = $urandom_range(0, pc);
               else len = $urandom_range(0, (pc < 48) ? pc : 48);
               first = $urandom_range(0, pc - len);
               if ($urandom_range(0, 11) == 0) len = len + $urandom_range(1, 4);
               if (first > 1023) first = 1023;
            end
            pba_pkg::OP_TEST: begin
               first = $urandom_range(0, (pc == 0) ? 0 : pc - 1);
               if (first > 1023) first = 1023;
               len = $urandom_range(0, 2047);
            end
            pba_pkg::OP_FIND: begin
               if ($urandom_range(0, 7) == 0) len = $urandom_range(0, pc + 2);
               else len = $urandom_range(1, 40);
               first = $urandom_range(0, 1023);
            end
            default: begin
               first = $urandom_range(0, 1023);
               len = $urandom_range(0, 2047);
            end
         endcase
         issue_request(op, START_W'(first), PAGE_W'(len));
      end
   endtask

   task automatic test_directed_edges();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      issue_request(pba_pkg::OP_COUNT, 0, 0);
      issue_request(pba_pkg::OP_FIND, 0, 1024);
      issue_request(pba_pkg::OP_FIND, 0, 0);
      issue_request(pba_pkg::OP_FIND, 0, 1025);
      issue_request(pba_pkg::OP_TEST, 1023, 0);
      issue_request(pba_pkg::OP_SET, 0, 1);
      issue_request(pba_pkg::OP_SET, 1023, 1);
      issue_request(pba_pkg::OP_SET, 1000, 25);
      issue_request(pba_pkg::OP_SET, 1000, 24);
      issue_request(pba_pkg::OP_SET, 5, 0);
      issue_request(pba_pkg::OP_SET, 1023, 2047);
      issue_request(pba_pkg::OP_CLEAR, 1023, 2047);
      issue_request(pba_pkg::OP_SET, 1, 2047);
      issue_request(pba_pkg::OP_TEST, 0, 0);
      issue_request(pba_pkg::OP_TEST, 1023, 2047);
      issue_request(pba_pkg::OP_FIND, 1023, 1024);
      issue_request(pba_pkg::OP_FIND, 0, 1);
      issue_request(pba_pkg::OP_SET, 20, 60);
      issue_request(pba_pkg::OP_FIND, 0, 30);
      issue_request(pba_pkg::OP_COUNT, 1023, 2047);
      issue_request(pba_pkg::OP_CLEAR, 30, 10);
      issue_request(pba_pkg::OP_FIND, 0, 10);
      issue_request(pba_pkg::OP_CLEAR, 0, 1024);
      issue_request(OP_UNDEF_A, 1023, 2047);
      issue_request(OP_UNDEF_B, 0, 1);
      issue_request(OP_UNDEF_C, 512, 1024);
      issue_request(pba_pkg::OP_COUNT, 0, 0);
   endtask

   // Zone sizes at and past the ends; bits above the zone stay invisible
   task automatic test_zone_limits();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      issue_request(pba_pkg::OP_SET, 900, 124);
      write_page_count(11'd100);
      issue_request(pba_pkg::OP_COUNT, 0, 0);
      issue_request(pba_pkg::OP_FIND, 0, 100);
      issue_request(pba_pkg::OP_FIND, 0, 101);
      issue_request(pba_pkg::OP_TEST, 950, 0);
      issue_request(pba_pkg::OP_SET, 90, 11);
      write_page_count(11'd0);
      issue_request(pba_pkg::OP_COUNT, 0, 0);
      issue_request(pba_pkg::OP_FIND, 0, 1);
      issue_request(pba_pkg::OP_TEST, 0, 0);
      issue_request(pba_pkg::OP_SET, 0, 0);
      issue_request(pba_pkg::OP_CLEAR, 0, 1);
      write_page_count(11'd1);
      issue_request(pba_pkg::OP_TEST, 0, 0);
      issue_request(pba_pkg::OP_FIND, 0, 1);
      issue_request(pba_pkg::OP_SET, 0, 1);
      issue_request(pba_pkg::OP_FIND, 0, 1);
      write_page_count(11'd2047);
      issue_request(pba_pkg::OP_COUNT, 0, 0);
      issue_request(pba_pkg::OP_FIND, 0, 1024);
      issue_request(pba_pkg::OP_CLEAR, 0, 1024);
      issue_request(pba_pkg::OP_FIND, 0, 1024);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int items,
                                      input logic [PAGE_W-1:0] pages);
      int n;
      write_page_count(pages);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < items; n++) issue_random_item();
   endtask

   // Stall the response side for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      int n;
      quiesce();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         hold_cycles = HOLD_OFF_CYCLES;
         for (n = 0; n < 30; n++) issue_random_item();
      join
   endtask

   // Response side ready, with a cycle-counted hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         observed_result = {rsp_bus.status, rsp_bus.page_index, rsp_bus.bit_value,
                            rsp_bus.used_count, rsp_bus.free_count};
         if (pending_results.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected response: status=%0d index=%0d bit=%0d used=%0d free=%0d",
                        observed_result.status, observed_result.page_index,
                        observed_result.bit_value, observed_result.used_count,
                        observed_result.free_count);
            mismatch_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (observed_result.status !== oldest_result.status ||
                observed_result.page_index !== oldest_result.page_index ||
                observed_result.bit_value !== oldest_result.bit_value ||
                observed_result.used_count !== oldest_result.used_count ||
                observed_result.free_count !== oldest_result.free_count) begin
               if (mismatch_count < 10)
                  $display("mismatch: expected status=%0d index=%0d bit=%0d used=%0d free=%0d, %s",
                           oldest_result.status, oldest_result.page_index,
                           oldest_result.bit_value, oldest_result.used_count,
                           oldest_result.free_count,
                           $sformatf("got status=%0d index=%0d bit=%0d used=%0d free=%0d",
                                     observed_result.status, observed_result.page_index,
                                     observed_result.bit_value, observed_result.used_count,
                                     observed_result.free_count));
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int k;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.operation  = '0;
      req_bus.start_page = '0;
      req_bus.length     = '0;
      rsp_bus.ready      = 1'b0;
      mismatch_count     = 0;
      cycle_count        = 0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      hold_cycles        = 0;
      zone_pages         = pba_pkg::PAGE_COUNT_RESET;
      for (k = 0; k < ZONE_WORDS; k++) shadow_words[k] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_edges();
      test_zone_limits();
      test_random_traffic(0, 0, 170, 11'd1024);
      test_random_traffic(77, 0, 170, 11'd2047);
      test_random_traffic(0, 77, 170, 11'd37);
      test_random_traffic(6, 6, 170, PAGE_W'($urandom_range(0, 2047)));
      test_output_backpressure();

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
